// ===== hdl/itoaf_pkg.sv =====
// ----------------------------------------------------------------------------
// itoaf_pkg
// Shared types, constants and controller/datapath link structs for the
// integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoaf_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 64;
  localparam int PREC_LIMIT = 62;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_BITS   = BCD_DIGITS * 4;
  localparam int LEN_W      = $clog2(MAX_CHARS + 1);
  localparam int POS_W      = $clog2(MAX_CHARS);
  localparam int CNT_W      = $clog2(VALUE_BITS);

  // conversion modes
  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_OCT  = 3'd1;
  localparam logic [2:0] MODE_UDEC = 3'd2;
  localparam logic [2:0] MODE_BIN  = 3'd3;
  localparam logic [2:0] MODE_HEXL = 3'd4;
  localparam logic [2:0] MODE_HEXU = 3'd5;
  localparam logic [2:0] MODE_PTR  = 3'd6;

  // ASCII
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [2:0]            mode;
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            precision;
    logic [7:0]            min_width;
    logic                  space_flag;
    logic                  plus_flag;
    logic                  zero_flag;
    logic                  alt_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       character;
    logic             last;
    logic             empty_res;
    logic [LEN_W-1:0] field_length;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             conv_step;
    logic             scan_load;
    logic             scan_step;
    logic             calc;
    logic             fill_step;
    logic             rd_en;
    logic [POS_W-1:0] addr;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             is_dec;
    logic             scan_zero;
    logic [LEN_W-1:0] len;
  } dp_sts_t;

endpackage

// ===== hdl/itoaf_dp.sv =====
// ----------------------------------------------------------------------------
// itoaf_dp
// Formatter datapath: operand capture, binary-to-BCD conversion, digit
// counting, field length rules, digit store and character decode.
// ----------------------------------------------------------------------------
module itoaf_dp (
  input  logic                 clk,
  input  itoaf_pkg::in_item_t  in_data,
  input  itoaf_pkg::dp_cmd_t   cmd,
  output itoaf_pkg::dp_sts_t   sts,
  output itoaf_pkg::out_item_t out_data
);
  import itoaf_pkg::*;

  // digit widths in bits
  localparam logic [2:0] STEP_BIN = 3'd1;
  localparam logic [2:0] STEP_OCT = 3'd3;
  localparam logic [2:0] STEP_NIB = 3'd4;

  logic [2:0]            mode_r;
  logic [VALUE_BITS-1:0] work_r;
  logic [BCD_BITS-1:0]   bcd_r;
  logic [BCD_BITS-1:0]   scan_r;
  logic [LEN_W-1:0]      digits_r;
  logic [5:0]            prec_r;
  logic [7:0]            mfw_r;
  logic                  sp_r, pl_r, zf_r, alt_r;
  logic                  neg_r, vzero_r, is_dec_r, upper_r;
  logic [2:0]            step_r;
  logic [LEN_W-1:0]      len_r;
  logic [7:0]            sign_r, pfx_r;
  logic [3:0]            rdata_r;
  logic [3:0]            mem [MAX_CHARS];

  function automatic logic [BCD_BITS-1:0] shr_step(input logic [BCD_BITS-1:0] x,
                                                   input logic [2:0] s);
    case (s)
      STEP_BIN: shr_step = x >> 1;
      STEP_OCT: shr_step = x >> 3;
      default:  shr_step = x >> 4;
    endcase
  endfunction

  function automatic logic [3:0] step_mask(input logic [2:0] s);
    case (s)
      STEP_BIN: step_mask = 4'h1;
      STEP_OCT: step_mask = 4'h7;
      default:  step_mask = 4'hF;
    endcase
  endfunction

  // operand capture
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [2:0]            in_step;
  logic [5:0]            in_prec;

  always_comb begin
    in_neg  = (in_data.mode == MODE_SDEC) && in_data.value[VALUE_BITS-1];
    in_mag  = in_neg ? (~in_data.value + VALUE_BITS'(1)) : in_data.value;
    in_prec = (in_data.precision > 6'(PREC_LIMIT)) ? 6'(PREC_LIMIT) : in_data.precision;
    unique case (in_data.mode)
      MODE_OCT: in_step = STEP_OCT;
      MODE_BIN: in_step = STEP_BIN;
      default:  in_step = STEP_NIB;
    endcase
  end

  // double-dabble: add 3 to every BCD digit >= 5, then shift in next bit
  logic [BCD_BITS-1:0] bcd_adj;
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3
                                                    : bcd_r[4*j +: 4];
    end
  end

  logic [BCD_BITS-1:0] src;
  logic [3:0]          fill_digit;
  assign src        = is_dec_r ? bcd_r : BCD_BITS'(work_r);
  assign fill_digit = src[3:0] & step_mask(step_r);

  // field length rules
  logic [LEN_W-1:0] prec_ext, size_max, size_b;
  logic             absorb, oct_extra, hex_pfx;
  logic [7:0]       sign_c, pfx_c;
  logic [7:0]       len8;
  logic [LEN_W-1:0] len_c;

  always_comb begin
    prec_ext  = LEN_W'(prec_r);
    size_max  = (digits_r > prec_ext) ? digits_r : prec_ext;
    size_b    = (vzero_r && prec_r == 6'd0 && !zf_r) ? '0 : size_max;
    absorb    = zf_r && ((mfw_r >= 8'(size_b)) || vzero_r);
    oct_extra = alt_r && (digits_r > prec_ext) && (!vzero_r || prec_r == 6'd0);
    hex_pfx   = (mode_r == MODE_PTR) || (alt_r && !vzero_r);
    sign_c    = CH_NONE;
    pfx_c     = CH_NONE;
    unique case (mode_r)
      MODE_SDEC: begin
        sign_c = neg_r ? CH_MINUS : pl_r ? CH_PLUS : sp_r ? CH_SPACE : CH_NONE;
        len8   = 8'(size_b) + 8'((sign_c != CH_NONE) && !absorb);
      end
      MODE_OCT: len8 = 8'(size_b) + 8'(oct_extra);
      MODE_UDEC, MODE_BIN: len8 = 8'(size_b);
      MODE_HEXL, MODE_HEXU, MODE_PTR: begin
        len8 = 8'(size_b) + ((hex_pfx && !absorb) ? 8'd2 : 8'd0);
        if (hex_pfx) pfx_c = (mode_r == MODE_HEXU) ? CH_UX : CH_LX;
      end
      default: len8 = 8'd0;
    endcase
    len_c = (len8 > 8'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : LEN_W'(len8);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_data.mode;
      work_r   <= in_mag;
      bcd_r    <= '0;
      prec_r   <= in_prec;
      mfw_r    <= in_data.min_width;
      sp_r     <= in_data.space_flag;
      pl_r     <= in_data.plus_flag;
      zf_r     <= in_data.zero_flag;
      alt_r    <= in_data.alt_flag;
      neg_r    <= in_neg;
      vzero_r  <= (in_data.value == '0);
      is_dec_r <= (in_data.mode == MODE_SDEC) || (in_data.mode == MODE_UDEC);
      upper_r  <= (in_data.mode == MODE_HEXU);
      step_r   <= in_step;
    end else if (cmd.conv_step) begin
      bcd_r  <= {bcd_adj[BCD_BITS-2:0], work_r[VALUE_BITS-1]};
      work_r <= work_r << 1;
    end else if (cmd.fill_step) begin
      if (is_dec_r) bcd_r <= bcd_r >> 4;
      else          work_r <= VALUE_BITS'(shr_step(BCD_BITS'(work_r), step_r));
    end

    if (cmd.scan_load) begin
      scan_r   <= shr_step(src, step_r);
      digits_r <= LEN_W'(1);
    end else if (cmd.scan_step) begin
      scan_r   <= shr_step(scan_r, step_r);
      digits_r <= digits_r + LEN_W'(1);
    end

    if (cmd.calc) begin
      len_r  <= len_c;
      sign_r <= sign_c;
      pfx_r  <= pfx_c;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.fill_step) mem[cmd.addr] <= fill_digit;
    if (cmd.rd_en)     rdata_r <= mem[cmd.addr];
  end

  // character decode
  logic [7:0] ch;
  always_comb begin
    if (rdata_r > 4'd9) ch = (upper_r ? CH_UA : CH_LA) + {4'b0, rdata_r} - 8'd10;
    else                ch = CH_ZERO + {4'b0, rdata_r};
    if (cmd.addr == POS_W'(0) && sign_r != CH_NONE) ch = sign_r;
    if (cmd.addr == POS_W'(1) && pfx_r != CH_NONE)  ch = pfx_r;
    if (len_r == '0) ch = CH_NONE;
  end

  assign out_data.character    = ch;
  assign out_data.last         = cmd.last;
  assign out_data.empty_res    = (len_r == '0);
  assign out_data.field_length = len_r;

  assign sts.is_dec    = is_dec_r;
  assign sts.scan_zero = (scan_r == '0);
  assign sts.len       = len_r;

endmodule

// ===== hdl/itoaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoaf_ctrl
// Formatter controller: sequences capture, BCD conversion, digit count,
// length calculation, digit store fill and character transfer.
// ----------------------------------------------------------------------------
module itoaf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  itoaf_pkg::dp_sts_t sts,
  output itoaf_pkg::dp_cmd_t cmd
);
  import itoaf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CONV  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_COUNT = 9'b000001000,
    S_CALC  = 9'b000010000,
    S_ALIGN = 9'b000100000,
    S_FILL  = 9'b001000000,
    S_READ  = 9'b010000000,
    S_SEND  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] conv_r, conv_nxt;
  logic             last;

  assign last = (sts.len == '0) || ((LEN_W'(pos_r) + LEN_W'(1)) == sts.len);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    conv_nxt  = conv_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.addr  = pos_r;
    cmd.last  = last;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          conv_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // only decimal modes need the BCD pass
        if (!sts.is_dec) begin
          state_nxt = S_PREP;
        end else begin
          cmd.conv_step = 1'b1;
          conv_nxt      = conv_r + CNT_W'(1);
          if (conv_r == CNT_W'(VALUE_BITS - 1)) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.scan_load = 1'b1;
        state_nxt     = S_COUNT;
      end
      S_COUNT: begin
        if (sts.scan_zero) state_nxt = S_CALC;
        else               cmd.scan_step = 1'b1;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        if (sts.len == '0) begin
          state_nxt = S_SEND;
        end else begin
          pos_nxt   = POS_W'(sts.len - LEN_W'(1));
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        // digits go in least significant first, from the right end
        cmd.fill_step = 1'b1;
        if (pos_r == '0) state_nxt = S_READ;
        else             pos_nxt   = pos_r - POS_W'(1);
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      conv_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      conv_r  <= conv_nxt;
    end
  end

endmodule

// ===== hdl/integer_to_ascii_formatter_top.sv =====
// Sequence: capture, BCD pass (decimal modes only), digit count, length
//   calculation and alignment, store fill, then a read and a send per character.
// Throughput: one item at a time; a new item is accepted only after the last
//   character of the current item has been sent.
// Reset: synchronous, active low; controller returns to idle, digit store is
//   not cleared.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// printf-style integer field formatter, one ASCII character per transfer.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  itoaf_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output itoaf_pkg::out_item_t out_data
);
  import itoaf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  itoaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoaf_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
